>>> rtl/core/dpc_pkg.sv
// Shared types and constants for the divisor partition counter.
// Used by dpc_ctrl, dpc_datapath and the top level; no dependencies of its own.
package dpc_pkg;

  localparam int N_W       = 9;
  localparam int CNT_W     = 63;
  localparam int WAY_W     = 64;
  localparam int MAX_N_DEF = 256;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic init_step;
    logic div_start;
    logic div_step;
    logic d_next;
    logic sweep_start;
    logic sweep_issue;
    logic fin_valid;
    logic fin_invalid;
  } dpc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_bad;
    logic i_at_n;
    logic div_last;
    logic div_zero;
    logic d_last;
  } dpc_sts_t;

endpackage

>>> rtl/core/dpc_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module dpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/core/dpc_datapath.sv
// Datapath: index counters, bit-serial remainder unit, the two way tables
// and the add/write stage of the table sweep. Depends on dpc_pkg, dpc_ram.
module dpc_datapath import dpc_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [N_W-1:0]   in_n_value,
  input  dpc_cmd_t         cmd,
  output dpc_sts_t         sts,
  output logic [CNT_W-1:0] out_count,
  output logic             out_invalid,
  output logic             out_overflow
);

  localparam int DEPTH = MAX_N + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int BIT_W = $clog2(IDX_W + 1);

  logic [IDX_W-1:0] n_r, d_r, i_r, rem_r, nsh_r, wr_idx_r;
  logic [BIT_W-1:0] bit_r;
  logic             s1_vld_r, s1_first_r, ovf_r;
  logic [WAY_W-1:0] prev_all_r;
  logic [CNT_W-1:0] count_r;
  logic             invalid_r, overflow_r;

  logic [IDX_W:0]   rem_tmp, d_ext, rem_sub;
  logic [IDX_W-1:0] rem_step;
  logic             d_one;
  logic [WAY_W-1:0] rda_all, rdb_all, rda_no, rdb_no;
  logic [WAY_W-1:0] a_all, init_dat, wdat_all, wdat_no, diff;
  logic [WAY_W:0]   sum_all, sum_no;
  logic             ovf_all, ovf_no;
  logic             we_all, we_no;
  logic [IDX_W-1:0] waddr, raddr_b;

  // Remainder unit: one dividend bit per step
  assign rem_tmp  = {rem_r, nsh_r[IDX_W-1]};
  assign d_ext    = {1'b0, d_r};
  assign rem_sub  = rem_tmp - d_ext;
  assign rem_step = (rem_tmp >= d_ext) ? rem_sub[IDX_W-1:0] : rem_tmp[IDX_W-1:0];

  assign sts.n_bad    = (in_n_value == '0) || (32'(in_n_value) > 32'(MAX_N));
  assign sts.i_at_n   = (i_r == n_r);
  assign sts.div_last = (bit_r == BIT_W'(IDX_W - 1));
  assign sts.div_zero = (rem_step == '0);
  assign sts.d_last   = (d_r == n_r);

  assign d_one = (d_r == IDX_W'(1));

  // With part 1 the lower entry was written last cycle: forward it
  assign a_all   = (d_one && !s1_first_r) ? prev_all_r : rdb_all;
  assign sum_all = {1'b0, a_all} + {1'b0, rda_all};
  assign sum_no  = {1'b0, rdb_no} + {1'b0, rda_no};
  assign ovf_all = sum_all[WAY_W] | sum_all[WAY_W-1];
  assign ovf_no  = sum_no[WAY_W] | sum_no[WAY_W-1];

  assign init_dat = (i_r == '0) ? WAY_W'(1) : '0;
  assign we_all   = cmd.init_step | s1_vld_r;
  assign we_no    = cmd.init_step | (s1_vld_r & ~d_one);
  assign waddr    = s1_vld_r ? wr_idx_r : i_r;
  assign wdat_all = s1_vld_r ? sum_all[WAY_W-1:0] : init_dat;
  assign wdat_no  = s1_vld_r ? sum_no[WAY_W-1:0] : init_dat;
  assign raddr_b  = i_r - d_r;

  assign diff = rda_all - rda_no;

  dpc_ram #(.WIDTH(WAY_W), .DEPTH(DEPTH)) u_ways_all (
    .clk    (clk),
    .we     (we_all),
    .waddr  (waddr),
    .wdata  (wdat_all),
    .raddr_a(i_r),
    .rdata_a(rda_all),
    .raddr_b(raddr_b),
    .rdata_b(rdb_all)
  );

  dpc_ram #(.WIDTH(WAY_W), .DEPTH(DEPTH)) u_ways_no_one (
    .clk    (clk),
    .we     (we_no),
    .waddr  (waddr),
    .wdata  (wdat_no),
    .raddr_a(i_r),
    .rdata_a(rda_no),
    .raddr_b(raddr_b),
    .rdata_b(rdb_no)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.sweep_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= IDX_W'(in_n_value);
      d_r   <= IDX_W'(1);
      ovf_r <= 1'b0;
    end else begin
      if (cmd.d_next) begin
        d_r <= d_r + IDX_W'(1);
      end
      if (s1_vld_r && (ovf_all || (!d_one && ovf_no))) begin
        ovf_r <= 1'b1;
      end
    end

    // Hold the index at n rather than wrap past it
    if (cmd.load) begin
      i_r <= '0;
    end else if (cmd.sweep_start) begin
      i_r <= d_r;
    end else if ((cmd.init_step || cmd.sweep_issue) && !sts.i_at_n) begin
      i_r <= i_r + IDX_W'(1);
    end

    if (cmd.div_start) begin
      rem_r <= '0;
      nsh_r <= n_r;
      bit_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_step;
      nsh_r <= {nsh_r[IDX_W-2:0], 1'b0};
      bit_r <= bit_r + BIT_W'(1);
    end

    s1_first_r <= cmd.sweep_issue && (i_r == d_r);
    wr_idx_r   <= i_r;
    if (s1_vld_r) begin
      prev_all_r <= sum_all[WAY_W-1:0];
    end

    if (cmd.fin_valid) begin
      count_r    <= diff[CNT_W-1:0];
      invalid_r  <= 1'b0;
      overflow_r <= ovf_r;
    end else if (cmd.fin_invalid) begin
      count_r    <= '0;
      invalid_r  <= 1'b1;
      overflow_r <= 1'b0;
    end
  end

  assign out_count    = count_r;
  assign out_invalid  = invalid_r;
  assign out_overflow = overflow_r;

endmodule

>>> rtl/core/dpc_ctrl.sv
// Controller: sequences table clear, divisor tests, table sweeps and the
// final read. Depends on dpc_pkg for the command and status types.
module dpc_ctrl import dpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_strobe,
  output dpc_cmd_t cmd,
  input  dpc_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_DIV,
    S_SWEEP,
    S_SW_END,
    S_RD_N,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (sts.n_bad) begin
            cmd.fin_invalid = 1'b1;
            strobe_nxt      = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.i_at_n) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          if (sts.div_zero) begin
            cmd.sweep_start = 1'b1;
            state_nxt       = S_SWEEP;
          end else begin
            // not a divisor: advance and test the next one
            cmd.d_next    = 1'b1;
            cmd.div_start = 1'b1;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep_issue = 1'b1;
        if (sts.i_at_n) begin
          state_nxt = S_SW_END;
        end
      end
      S_SW_END: begin
        // last write of the pass lands this cycle
        if (sts.d_last) begin
          state_nxt = S_RD_N;
        end else begin
          cmd.d_next    = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_RD_N: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin_valid = 1'b1;
        strobe_nxt    = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

endmodule

>>> rtl/core/divisor_partition_counter.sv
// Divisor partition counter: for n, counts partitions of n into divisors of
// n that contain a part 1. Top level; depends on dpc_pkg, dpc_ctrl, dpc_datapath.
//
// Pulse start with in_n_value while busy is low. The result appears on
// out_count, out_invalid and out_overflow, marked by out_strobe high for
// exactly one cycle; there is no backpressure, so the receiver must take it
// then. An n of zero or above MAX_N gives invalid with zero count in the
// cycle after the transfer. A valid n is handled in steps: one table entry
// cleared a cycle, a bit-serial remainder unit testing each candidate
// divisor at one bit a cycle, and one table entry updated a cycle per
// divisor through the single write port of each way table.
// A new start is taken in the cycle the result is shown.
module divisor_partition_counter import dpc_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [N_W-1:0]   in_n_value,
  output logic             out_strobe,
  output logic [CNT_W-1:0] out_count,
  output logic             out_invalid,
  output logic             out_overflow
);

  dpc_cmd_t cmd;
  dpc_sts_t sts;

  dpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_strobe(out_strobe),
    .cmd       (cmd),
    .sts       (sts)
  );

  dpc_datapath #(.MAX_N(MAX_N)) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_n_value  (in_n_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_count   (out_count),
    .out_invalid (out_invalid),
    .out_overflow(out_overflow)
  );

endmodule
